[hw/rtl/dtpp_pkg.sv]
// ----------------------------------------------------------------------------
// dtpp_pkg
// Shared types and constants for the display thermal power policy block.
// ----------------------------------------------------------------------------
package dtpp_pkg;

  localparam int unsigned TempW  = 20;
  localparam int unsigned HystW  = 17;
  localparam int unsigned MsW    = 16;
  localparam int unsigned PctW   = 7;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  localparam logic [PctW-1:0] PctMax = 7'd100;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_POLL    = 2'd1,
    ACT_SUSPEND = 2'd2,
    ACT_RESUME  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    DISP_OFF     = 2'd0,
    DISP_ON      = 2'd1,
    DISP_UNKNOWN = 2'd2
  } disp_e;

  typedef enum logic [1:0] {
    TRANS_NONE = 2'd0,
    TRANS_OFF  = 2'd1,
    TRANS_ON   = 2'd2
  } trans_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD  = 3'd0,
    CFG_HYSTERESIS = 3'd1,
    CFG_HOLD_TIME  = 3'd2,
    CFG_RECHECK    = 3'd3,
    CFG_CHARGE_PCT = 3'd4,
    CFG_DOZE_PCT   = 3'd5,
    CFG_BOOST_PCT  = 3'd6,
    CFG_BOOST_TIME = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [TempW-1:0] threshold;
    logic [HystW-1:0]        hysteresis;
    logic [MsW-1:0]          hold_time;
    logic [MsW-1:0]          recheck;
    logic [PctW-1:0]         charge_pct;
    logic [PctW-1:0]         doze_pct;
    logic [PctW-1:0]         boost_pct;
    logic [MsW-1:0]          boost_time;
  } cfg_t;

  typedef struct packed {
    logic [1:0]              action;
    logic                    display_valid;
    logic                    display_on;
    logic                    charging;
    logic signed [TempW-1:0] peak_temp;
  } item_t;

  typedef struct packed {
    logic            pinned;
    logic [PctW-1:0] pin_percent;
    logic            cores_restricted;
    logic            io_restricted;
    logic            screen_off;
    logic            thermal_hold;
    logic            boost_active;
    logic [1:0]      transition;
  } result_t;

  typedef struct packed {
    logic            screen_is_off;
    disp_e           last_display;
    logic            asleep;
    logic            resync_pending;
    logic            hold_active;
    logic [MsW-1:0]  hold_remaining;
    logic            boost_on;
    logic [MsW-1:0]  boost_remaining;
    logic            pin_state;
    logic [PctW-1:0] pin_level;
    logic            restricted;
  } state_t;

  function automatic logic [PctW-1:0] sat_pct(input logic [PctW-1:0] pct);
    return (pct > PctMax) ? PctMax : pct;
  endfunction

endpackage

[hw/rtl/display_thermal_power_policy.sv]
// ----------------------------------------------------------------------------
// display_thermal_power_policy
// Screen-state power policy with thermal hold and wake boost.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries one event per beat: a one
// millisecond tick, a poll sample, suspend-prepare or resume-done. Each beat
// yields exactly one result beat on the output channel (out_valid_o /
// out_ready_i) with the pin, restriction, hold, boost and transition state
// after that event.
// Each input beat goes into one input register, then through the policy update
// into a result register. Throughput is one beat per cycle while the receiver
// takes results, set by the state update between the two registers.
// When the receiver stalls, the result register holds and the input register
// takes one more beat, then in_ready_o drops until the result is taken. Reset
// loads register defaults, clears policy state and marks the last display
// state as unknown. Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i)
// take effect at the clock edge; the user makes them while idle, unenforced.
// ----------------------------------------------------------------------------
module display_thermal_power_policy (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dtpp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [dtpp_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         action_i,
  input  logic                               display_valid_i,
  input  logic                               display_on_i,
  input  logic                               charging_i,
  input  logic signed [dtpp_pkg::TempW-1:0]  peak_temp_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               pinned_o,
  output logic [dtpp_pkg::PctW-1:0]          pin_percent_o,
  output logic                               cores_restricted_o,
  output logic                               io_restricted_o,
  output logic                               screen_off_o,
  output logic                               thermal_hold_o,
  output logic                               boost_active_o,
  output logic [1:0]                         transition_o
);
  import dtpp_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  result_t res_d, res_q;
  logic    in_valid_q, out_valid_q;
  logic    advance;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  dtpp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dtpp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (in_valid_q && advance),
    .cfg_i  (cfg),
    .item_i (item_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.action        <= action_i;
      item_q.display_valid <= display_valid_i;
      item_q.display_on    <= display_on_i;
      item_q.charging      <= charging_i;
      item_q.peak_temp     <= peak_temp_i;
    end
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign pinned_o           = res_q.pinned;
  assign pin_percent_o      = res_q.pin_percent;
  assign cores_restricted_o = res_q.cores_restricted;
  assign io_restricted_o    = res_q.io_restricted;
  assign screen_off_o       = res_q.screen_off;
  assign thermal_hold_o     = res_q.thermal_hold;
  assign boost_active_o     = res_q.boost_active;
  assign transition_o       = res_q.transition;

  a_restrict_tracks_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cores_restricted_o == screen_off_o))
    else $error("restriction out of step with screen state");

  a_boost_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && boost_active_o) |-> (pinned_o && !thermal_hold_o))
    else $error("boost running without pin or during hold");

  a_trans_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && transition_o != TRANS_NONE) |->
      (screen_off_o == (transition_o == TRANS_OFF)))
    else $error("transition disagrees with screen state");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pin_percent_o <= PctMax && (pinned_o || pin_percent_o == '0)))
    else $error("pin percent out of range");

endmodule

[hw/rtl/dtpp_cfg.sv]
// ----------------------------------------------------------------------------
// dtpp_cfg
// Configuration register file with reset defaults.
// ----------------------------------------------------------------------------
module dtpp_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dtpp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dtpp_pkg::CfgDataW-1:0]   cfg_data_i,
  output dtpp_pkg::cfg_t                  cfg_o
);
  import dtpp_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_THRESHOLD:  cfg_d.threshold  = cfg_data_i[TempW-1:0];
        CFG_HYSTERESIS: cfg_d.hysteresis = cfg_data_i[HystW-1:0];
        CFG_HOLD_TIME:  cfg_d.hold_time  = cfg_data_i[MsW-1:0];
        CFG_RECHECK:    cfg_d.recheck    = cfg_data_i[MsW-1:0];
        CFG_CHARGE_PCT: cfg_d.charge_pct = cfg_data_i[PctW-1:0];
        CFG_DOZE_PCT:   cfg_d.doze_pct   = cfg_data_i[PctW-1:0];
        CFG_BOOST_PCT:  cfg_d.boost_pct  = cfg_data_i[PctW-1:0];
        CFG_BOOST_TIME: cfg_d.boost_time = cfg_data_i[MsW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold  <= 20'sd65000;
      cfg_q.hysteresis <= 17'd5000;
      cfg_q.hold_time  <= 16'd3000;
      cfg_q.recheck    <= 16'd1000;
      cfg_q.charge_pct <= 7'd20;
      cfg_q.doze_pct   <= 7'd10;
      cfg_q.boost_pct  <= 7'd100;
      cfg_q.boost_time <= 16'd1200;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/dtpp_core.sv]
// ----------------------------------------------------------------------------
// dtpp_core
// Policy state and its update for one registered item.
// ----------------------------------------------------------------------------
module dtpp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  dtpp_pkg::cfg_t    cfg_i,
  input  dtpp_pkg::item_t   item_i,
  output dtpp_pkg::result_t res_o
);
  import dtpp_pkg::*;

  state_t st_q, st_d;

  logic signed [TempW+1:0] cool_lim;
  logic signed [TempW+1:0] temp_ext;
  logic                    cooled;
  logic                    hot;
  trans_e                  trans;

  assign cool_lim = {{2{cfg_i.threshold[TempW-1]}}, cfg_i.threshold}
                  - $signed({{(TempW+2-HystW){1'b0}}, cfg_i.hysteresis});
  assign temp_ext = {{2{item_i.peak_temp[TempW-1]}}, item_i.peak_temp};
  assign cooled   = temp_ext < cool_lim;
  assign hot      = item_i.peak_temp >= cfg_i.threshold;

  always_comb begin
    disp_e cur_disp;
    st_d     = st_q;
    trans    = TRANS_NONE;
    cur_disp = item_i.display_on ? DISP_ON : DISP_OFF;
    case (action_e'(item_i.action))
      ACT_TICK: begin
        if (st_q.hold_remaining != '0) begin
          st_d.hold_remaining = st_q.hold_remaining - 1'b1;
        end
        if (st_q.boost_on) begin
          if (st_q.boost_remaining != '0) begin
            st_d.boost_remaining = st_q.boost_remaining - 1'b1;
          end
          if (st_d.boost_remaining == '0) begin
            if (!st_q.screen_is_off && !st_q.hold_active) begin
              st_d.pin_state = 1'b0;
              st_d.pin_level = '0;
            end
            st_d.boost_on = 1'b0;
          end
        end
      end
      ACT_POLL: begin
        if (!st_q.asleep) begin
          if (st_q.resync_pending) begin
            st_d.last_display   = DISP_UNKNOWN;
            st_d.resync_pending = 1'b0;
          end
          if (item_i.display_valid && cur_disp != st_d.last_display) begin
            if (cur_disp == DISP_OFF && !st_q.screen_is_off) begin
              st_d.boost_on        = 1'b0;
              st_d.boost_remaining = '0;
              st_d.pin_state       = 1'b1;
              st_d.pin_level       = sat_pct(item_i.charging ? cfg_i.charge_pct
                                                             : cfg_i.doze_pct);
              st_d.restricted      = 1'b1;
              st_d.screen_is_off   = 1'b1;
              if (hot) begin
                st_d.hold_active = 1'b1;
              end
              trans = TRANS_OFF;
            end else if (cur_disp == DISP_ON && st_q.screen_is_off) begin
              st_d.screen_is_off = 1'b0;
              st_d.restricted    = 1'b0;
              if (st_q.hold_active && !cooled) begin
                st_d.hold_remaining = cfg_i.hold_time;
              end else begin
                st_d.hold_active = 1'b0;
                st_d.pin_state   = 1'b0;
                st_d.pin_level   = '0;
                if (cfg_i.boost_pct != '0 && cfg_i.boost_time != '0) begin
                  st_d.boost_on        = 1'b1;
                  st_d.pin_state       = 1'b1;
                  st_d.pin_level       = sat_pct(cfg_i.boost_pct);
                  st_d.boost_remaining = cfg_i.boost_time;
                end
              end
              trans = TRANS_ON;
            end
            st_d.last_display = cur_disp;
          end
          if (st_d.hold_active && !st_d.screen_is_off && st_d.hold_remaining == '0) begin
            if (cooled) begin
              st_d.pin_state   = 1'b0;
              st_d.pin_level   = '0;
              st_d.hold_active = 1'b0;
            end else begin
              st_d.hold_remaining = cfg_i.recheck;
            end
          end
        end
      end
      ACT_SUSPEND: begin
        st_d.asleep = 1'b1;
      end
      ACT_RESUME: begin
        st_d.asleep         = 1'b0;
        st_d.resync_pending = 1'b1;
      end
      default: st_d = st_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.screen_is_off   <= 1'b0;
      st_q.last_display    <= DISP_UNKNOWN;
      st_q.asleep          <= 1'b0;
      st_q.resync_pending  <= 1'b0;
      st_q.hold_active     <= 1'b0;
      st_q.hold_remaining  <= '0;
      st_q.boost_on        <= 1'b0;
      st_q.boost_remaining <= '0;
      st_q.pin_state       <= 1'b0;
      st_q.pin_level       <= '0;
      st_q.restricted      <= 1'b0;
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  always_comb begin
    res_o.pinned           = st_d.pin_state;
    res_o.pin_percent      = st_d.pin_state ? st_d.pin_level : '0;
    res_o.cores_restricted = st_d.restricted;
    res_o.io_restricted    = st_d.restricted;
    res_o.screen_off       = st_d.screen_is_off;
    res_o.thermal_hold     = st_d.hold_active;
    res_o.boost_active     = st_d.boost_on;
    res_o.transition       = trans;
  end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for display_thermal_power_policy. Events go in over a valid/ready
// channel while the results are checked one by one, field by field, against
// a cycle-free model of the policy: screen-off pinning, thermal hold and its
// timed re-check, wake boost, and suspend/resume resync. The run covers a
// directed part, register extremes, randomized sessions under several
// register settings, and a long result stall.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dtpp_pkg::*;

  localparam int CycleLimit = 200000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]      cfg_idx_i = '0;
  logic [CfgDataW-1:0]     cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              action_i = ACT_TICK;
  logic                    display_valid_i = 1'b0;
  logic                    display_on_i = 1'b0;
  logic                    charging_i = 1'b0;
  logic signed [TempW-1:0] peak_temp_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    pinned_o;
  logic [PctW-1:0]         pin_percent_o;
  logic                    cores_restricted_o;
  logic                    io_restricted_o;
  logic                    screen_off_o;
  logic                    thermal_hold_o;
  logic                    boost_active_o;
  logic [1:0]              transition_o;

  display_thermal_power_policy dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .action_i           (action_i),
    .display_valid_i    (display_valid_i),
    .display_on_i       (display_on_i),
    .charging_i         (charging_i),
    .peak_temp_i        (peak_temp_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .pinned_o           (pinned_o),
    .pin_percent_o      (pin_percent_o),
    .cores_restricted_o (cores_restricted_o),
    .io_restricted_o    (io_restricted_o),
    .screen_off_o       (screen_off_o),
    .thermal_hold_o     (thermal_hold_o),
    .boost_active_o     (boost_active_o),
    .transition_o       (transition_o)
  );

  always #1 clk_i = ~clk_i;

  // Policy registers as last written
  logic signed [TempW-1:0] th_thr = 20'sd65000;
  logic [HystW-1:0]        th_hyst = 17'd5000;
  logic [MsW-1:0]          hold_t = 16'd3000;
  logic [MsW-1:0]          recheck_t = 16'd1000;
  logic [PctW-1:0]         chg_pct = 7'd20;
  logic [PctW-1:0]         doze_pct = 7'd10;
  logic [PctW-1:0]         boost_pct = 7'd100;
  logic [MsW-1:0]          boost_t = 16'd1200;

  // Policy state
  logic            scr_off = 1'b0;
  disp_e           last_disp = DISP_UNKNOWN;
  logic            sleeping = 1'b0;
  logic            resync = 1'b0;
  logic            hold_on = 1'b0;
  logic [MsW-1:0]  hold_left = '0;
  logic            boost_run = 1'b0;
  logic [MsW-1:0]  boost_left = '0;
  logic            pin_on = 1'b0;
  logic [PctW-1:0] pin_pct = '0;
  logic            restr = 1'b0;

  result_t outcome_q[$];
  int      sent = 0;
  int      mismatches = 0;
  int      cycle_cnt = 0;
  int      tx_idle_pct = 19;
  int      rx_idle_pct = 19;
  int      rx_hold = 0;

  function automatic void pin_to(logic [PctW-1:0] pct);
    pin_on = 1'b1;
    pin_pct = (pct > PctMax) ? PctMax : pct;
  endfunction

  function automatic result_t policy_after(item_t ev);
    result_t r;
    trans_e  tr;
    disp_e   seen;
    int      t;
    int      cool_lim;
    tr = TRANS_NONE;
    t = int'(ev.peak_temp);
    cool_lim = int'(th_thr) - int'(th_hyst);
    case (ev.action)
      ACT_TICK: begin
        if (hold_left != 0) hold_left--;
        if (boost_run) begin
          if (boost_left != 0) boost_left--;
          if (boost_left == 0) begin
            if (!scr_off && !hold_on) begin
              pin_on = 1'b0;
              pin_pct = '0;
            end
            boost_run = 1'b0;
          end
        end
      end
      ACT_POLL: begin
        if (!sleeping) begin
          if (resync) begin
            last_disp = DISP_UNKNOWN;
            resync = 1'b0;
          end
          seen = ev.display_on ? DISP_ON : DISP_OFF;
          if (ev.display_valid && seen != last_disp) begin
            if (seen == DISP_OFF && !scr_off) begin
              boost_run = 1'b0;
              boost_left = '0;
              pin_to(ev.charging ? chg_pct : doze_pct);
              restr = 1'b1;
              scr_off = 1'b1;
              if (t >= int'(th_thr)) hold_on = 1'b1;
              tr = TRANS_OFF;
            end else if (seen == DISP_ON && scr_off) begin
              scr_off = 1'b0;
              restr = 1'b0;
              if (hold_on && t >= cool_lim) begin
                hold_left = hold_t;
              end else begin
                hold_on = 1'b0;
                pin_on = 1'b0;
                pin_pct = '0;
                if (boost_pct != 0 && boost_t != 0) begin
                  boost_run = 1'b1;
                  pin_to(boost_pct);
                  boost_left = boost_t;
                end
              end
              tr = TRANS_ON;
            end
            last_disp = seen;
          end
          if (hold_on && !scr_off && hold_left == 0) begin
            if (t < cool_lim) begin
              pin_on = 1'b0;
              pin_pct = '0;
              hold_on = 1'b0;
            end else begin
              hold_left = recheck_t;
            end
          end
        end
      end
      ACT_SUSPEND: sleeping = 1'b1;
      default: begin
        sleeping = 1'b0;
        resync = 1'b1;
      end
    endcase
    r.pinned = pin_on;
    r.pin_percent = pin_on ? pin_pct : '0;
    r.cores_restricted = restr;
    r.io_restricted = restr;
    r.screen_off = scr_off;
    r.thermal_hold = hold_on;
    r.boost_active = boost_run;
    r.transition = tr;
    return r;
  endfunction

  function automatic string fmt_outcome(result_t r);
    return $sformatf("pin=%0d pct=%0d cores=%0d io=%0d off=%0d hold=%0d boost=%0d tr=%0d",
                     r.pinned, r.pin_percent, r.cores_restricted, r.io_restricted,
                     r.screen_off, r.thermal_hold, r.boost_active, r.transition);
  endfunction

  task automatic send_event(action_e act, bit dv, bit don, bit chg, int temp);
    item_t ev;
    ev = {act, dv, don, chg, temp[TempW-1:0]};
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    action_i = ev.action;
    display_valid_i = ev.display_valid;
    display_on_i = ev.display_on;
    charging_i = ev.charging;
    peak_temp_i = ev.peak_temp;
    do @(posedge clk_i); while (!in_ready_o);
    outcome_q.push_back(policy_after(ev));
    sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value[CfgDataW-1:0];
    @(posedge clk_i);
    case (idx)
      CFG_THRESHOLD:  th_thr = cfg_data_i;
      CFG_HYSTERESIS: th_hyst = cfg_data_i[HystW-1:0];
      CFG_HOLD_TIME:  hold_t = cfg_data_i[MsW-1:0];
      CFG_RECHECK:    recheck_t = cfg_data_i[MsW-1:0];
      CFG_CHARGE_PCT: chg_pct = cfg_data_i[PctW-1:0];
      CFG_DOZE_PCT:   doze_pct = cfg_data_i[PctW-1:0];
      CFG_BOOST_PCT:  boost_pct = cfg_data_i[PctW-1:0];
      default:        boost_t = cfg_data_i[MsW-1:0];
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic setup(int thr, int hyst, int hold, int recheck, int cpct, int dpct,
                       int bpct, int btime);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_HYSTERESIS, hyst);
    write_reg(CFG_HOLD_TIME, hold);
    write_reg(CFG_RECHECK, recheck);
    write_reg(CFG_CHARGE_PCT, cpct);
    write_reg(CFG_DOZE_PCT, dpct);
    write_reg(CFG_BOOST_PCT, bpct);
    write_reg(CFG_BOOST_TIME, btime);
  endtask

  function automatic int pick_temp(bit cool);
    case ($urandom_range(9))
      0: return int'($urandom);
      1: return -273000;
      2: return 250000;
      default: return (cool ? int'(th_thr) - int'(th_hyst) : int'(th_thr))
                      + int'($urandom_range(6)) - 3;
    endcase
  endfunction

  task automatic tick_n(int n);
    repeat (n) send_event(ACT_TICK, 1'($urandom), 1'($urandom), 1'($urandom), $urandom);
  endtask

  task automatic poll(bit on, int temp);
    send_event(ACT_POLL, 1'b1, on, 1'($urandom), temp);
  endtask

  task automatic noise_event();
    send_event(action_e'($urandom_range(3)), 1'($urandom), 1'($urandom), 1'($urandom),
               $urandom);
  endtask

  // One screen-off / screen-on cycle with ticks and re-check polls
  task automatic episode();
    poll(1'b0, pick_temp(1'b0));
    tick_n($urandom_range(4));
    if ($urandom_range(4) == 0) begin
      send_event(ACT_SUSPEND, 1'($urandom), 1'($urandom), 1'($urandom), $urandom);
      poll(1'($urandom), pick_temp(1'($urandom)));
      tick_n($urandom_range(2));
      send_event(ACT_RESUME, 1'($urandom), 1'($urandom), 1'($urandom), $urandom);
    end
    poll(1'b1, pick_temp(1'b1));
    repeat ($urandom_range(1, 5)) begin
      tick_n(($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(4));
      if ($urandom_range(7) == 0)
        send_event(ACT_POLL, 1'b0, 1'($urandom), 1'($urandom), $urandom);
      else poll(1'b1, pick_temp(1'b1));
    end
  endtask

  task automatic run_mix(int n);
    int stop;
    stop = sent + n;
    while (sent < stop) begin
      if ($urandom_range(99) < 80) episode();
      else noise_event();
    end
  endtask

  task automatic test_directed_events();
    send_event(ACT_POLL, 1'b0, 1'b1, 1'b0, 0);
    poll(1'b1, 0);
    send_event(ACT_POLL, 1'b1, 1'b0, 1'b1, 250000);
    tick_n(1);
    send_event(ACT_POLL, 1'b1, 1'b0, 1'b0, -273000);
    poll(1'b1, 250000);
    send_event(ACT_SUSPEND, 1'b0, 1'b0, 1'b0, 0);
    poll(1'b0, 0);
    tick_n(1);
    send_event(ACT_RESUME, 1'b1, 1'b1, 1'b1, -1);
    poll(1'b1, 524287);
    send_event(ACT_POLL, 1'b1, 1'b0, 1'b0, -524288);
    poll(1'b1, -273000);
    tick_n(1);
    drain();
    setup(0, 0, 2, 0, 127, 101, 127, 2);
    send_event(ACT_POLL, 1'b1, 1'b0, 1'b1, 0);
    poll(1'b1, 0);
    tick_n(2);
    poll(1'b1, 0);
    poll(1'b1, -1);
    send_event(ACT_POLL, 1'b1, 1'b0, 1'b0, -273000);
    poll(1'b1, -273000);
    tick_n(2);
    send_event(ACT_RESUME, 1'b0, 1'b0, 1'b0, 0);
    poll(1'b1, 0);
    drain();
  endtask

  task automatic test_register_extremes();
    setup(-273000, 0, 0, 1, 0, 0, 0, 0);
    run_mix(60);
    drain();
    setup(250000, 100000, 65535, 65535, 100, 100, 100, 65535);
    run_mix(50);
    drain();
    setup(-524288, 131071, 1, 1, 127, 127, 127, 1);
    run_mix(40);
    drain();
    setup(524287, 0, 0, 0, 1, 0, 1, 1);
    run_mix(40);
    drain();
    setup(20, 10, 5, 1, 127, 64, 1, 3);
    run_mix(50);
    drain();
  endtask

  task automatic test_random_sessions();
    for (int ph = 0; ph < 6; ph++) begin
      setup(int'($urandom_range(100000)) - 20000, $urandom_range(30000),
            $urandom_range(25), ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 12),
            $urandom_range(127), $urandom_range(127),
            ($urandom_range(5) == 0) ? 0 : $urandom_range(127), $urandom_range(30));
      if (ph == 2) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      run_mix(250);
      drain();
      tx_idle_pct = 19;
      rx_idle_pct = 19;
    end
  endtask

  task automatic test_output_backpressure();
    setup(30000, 2000, 6, 3, 55, 33, 90, 8);
    rx_hold = 400;
    run_mix(40);
    drain();
  endtask

  always @(negedge clk_i) begin
    if (rx_hold != 0) begin
      out_ready_i = 1'b0;
      rx_hold--;
    end else begin
      out_ready_i = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {pinned_o, pin_percent_o, cores_restricted_o, io_restricted_o,
             screen_off_o, thermal_hold_o, boost_active_o, transition_o};
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected beat: %s", fmt_outcome(got));
      end else begin
        want = outcome_q.pop_front();
        if (got.pinned !== want.pinned || got.pin_percent !== want.pin_percent ||
            got.cores_restricted !== want.cores_restricted ||
            got.io_restricted !== want.io_restricted ||
            got.screen_off !== want.screen_off || got.thermal_hold !== want.thermal_hold ||
            got.boost_active !== want.boost_active || got.transition !== want.transition)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: mismatch\n  want %s\n  got  %s", fmt_outcome(want),
                     fmt_outcome(got));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_events();
    test_register_extremes();
    test_random_sessions();
    test_output_backpressure();
    drain();
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/dtpp_pkg.sv
hw/rtl/dtpp_cfg.sv
hw/rtl/dtpp_core.sv
hw/rtl/display_thermal_power_policy.sv
test/tb.sv
